// File: design/bezier_de_casteljau_eval_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Bezier evaluator
// Short forms for same-cycle and next-cycle implications on clk and rst.
// ----------------------------------------------------------------------------
`ifndef BEZIER_DE_CASTELJAU_EVAL_CORE_MACROS_SVH
`define BEZIER_DE_CASTELJAU_EVAL_CORE_MACROS_SVH

// Same-cycle implication.
`define BDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Types and constants shared by the Bezier evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package bdc_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_EVAL   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_OVF   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_COPY,
    ST_DRAIN,
    ST_LEVEL,
    ST_EMIT,
    ST_EMIT_LD
  } st_t;

  localparam int T_BITS   = 17;
  localparam int LV_BITS  = 4;
  localparam logic [T_BITS-1:0] T_ONE = 17'd65536;
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    kind_t                kind;
    logic [T_BITS-1:0]    t;
    logic [LV_BITS-1:0]   levels;
  } cmd_ctl_t;

endpackage
`default_nettype wire

// File: design/bdc_front.sv
// ----------------------------------------------------------------------------
// bdc_front
// Takes input beats, drops unused kinds, saturates t and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module bdc_front #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   kind,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic [bdc_pkg::T_BITS-1:0]   t_param,
  input  wire logic [bdc_pkg::LV_BITS-1:0]  levels,
  input  wire logic                         q_full,
  output logic                              push,
  output bdc_pkg::cmd_ctl_t                 push_ctl,
  output logic [COORD_BITS-1:0]             push_x,
  output logic [COORD_BITS-1:0]             push_y
);
  import bdc_pkg::*;

  logic known;

  always_comb begin
    unique case (kind)
      KIND_APPEND, KIND_CLEAR, KIND_EVAL: known = 1'b1;
      default:                            known = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  // drop the unused kind here; it never reaches the back end
  assign push     = in_valid && !q_full && known;

  always_comb begin
    push_ctl.kind   = kind_t'(kind);
    push_ctl.t      = (t_param > T_ONE) ? T_ONE : t_param;
    push_ctl.levels = levels;
  end

  assign push_x = x_coord;
  assign push_y = y_coord;
endmodule
`default_nettype wire

// File: design/bdc_queue.sv
// ----------------------------------------------------------------------------
// bdc_queue
// Two-entry command queue between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module bdc_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              q_valid,
  output logic [W-1:0]      q_data
);
  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assign full    = fill == 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_data  = mem[rd_ptr];
endmodule
`default_nettype wire

// File: design/bdc_back.sv
// ----------------------------------------------------------------------------
// bdc_back
// Point store, work store, lerp pipeline and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bdc_back #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_pop,
  input  wire bdc_pkg::cmd_ctl_t             cmd_ctl,
  input  wire logic [COORD_BITS-1:0]         cmd_x,
  input  wire logic [COORD_BITS-1:0]         cmd_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_BITS-1:0]       out_x,
  output logic signed [COORD_BITS-1:0]       out_y,
  output logic                               last,
  output logic [1:0]                         status
);
  import bdc_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = AW + 1;
  localparam int LW    = (CNT_W > LV_BITS) ? CNT_W : LV_BITS;
  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int PW    = DW + T_BITS + 1;
  localparam int SW    = PW - FRAC_BITS;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_POINTS);
  localparam logic [PW-1:0]    HALF = PW'(1) << (FRAC_BITS - 1);

  st_t               state, state_next;
  logic [CNT_W-1:0]  count, count_next, n, n_next, lv, lv_next, j, j_next;
  logic [AW-1:0]     idx, idx_next;
  logic [T_BITS-1:0] t_reg, t_next;
  logic              emit_last, emit_last_next;
  status_t           err_stat, err_stat_next;
  logic [LW-1:0]     lv_req, lv_cap;

  logic [2*CB-1:0]   ps_mem [MAX_POINTS];
  logic [2*CB-1:0]   wk_mem [MAX_POINTS];
  logic [2*CB-1:0]   ps_rd, rd_a, rd_b, wk_wd;
  logic [AW-1:0]     ra_addr, rb_addr, wk_wa;
  logic              ps_we, wk_we, cp_issue, lv_issue;

  logic              cp_v, s1_v, s2_v;
  logic [AW-1:0]     cp_addr, s1_addr, s2_addr;
  logic signed [CB-1:0] s2_ax, s2_ay;
  logic signed [PW-1:0] s2_px, s2_py;
  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] px, py;
  logic signed [PW-1:0] rx_sum, ry_sum;
  logic signed [SW-1:0] rx, ry;
  logic signed [CB-1:0] nx, ny;

  logic              o_load, o_zero, o_last_n, free;
  logic [1:0]        o_stat_n;

  // -------- sequencer --------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    n         <= n_next;
    lv        <= lv_next;
    j         <= j_next;
    idx       <= idx_next;
    t_reg     <= t_next;
    emit_last <= emit_last_next;
    err_stat  <= err_stat_next;
  end

  assign free   = !out_valid || !out_stall;
  assign lv_req = LW'(cmd_ctl.levels);
  assign lv_cap = LW'(count) - LW'(1);

  always_comb begin
    state_next     = state;
    count_next     = count;
    n_next         = n;
    lv_next        = lv;
    j_next         = j;
    idx_next       = idx;
    t_next         = t_reg;
    emit_last_next = emit_last;
    err_stat_next  = err_stat;
    cmd_pop        = 1'b0;
    ps_we          = 1'b0;
    cp_issue       = 1'b0;
    lv_issue       = 1'b0;
    o_load         = 1'b0;
    o_zero         = 1'b0;
    o_last_n       = 1'b1;
    o_stat_n       = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd_ctl.kind)
            KIND_APPEND: begin
              if (count == FULL) begin
                err_stat_next = STAT_OVF;
                state_next    = ST_ERR;
              end else begin
                ps_we      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            KIND_CLEAR: count_next = '0;
            KIND_EVAL: begin
              if (count == '0) begin
                err_stat_next = STAT_EMPTY;
                state_next    = ST_ERR;
              end else begin
                n_next     = count;
                lv_next    = CNT_W'((lv_req > lv_cap) ? lv_cap : lv_req);
                t_next     = cmd_ctl.t;
                j_next     = '0;
                idx_next   = '0;
                state_next = ST_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ERR: begin
        if (free) begin
          o_load     = 1'b1;
          o_zero     = 1'b1;
          o_stat_n   = err_stat;
          state_next = ST_IDLE;
        end
      end
      ST_COPY: begin
        cp_issue = 1'b1;
        if ({1'b0, idx} == n - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_DRAIN: begin
        // hold until every write of the previous pass has landed
        if (!cp_v && !s1_v && !s2_v) begin
          idx_next   = '0;
          state_next = (j < lv) ? ST_LEVEL : ST_EMIT;
        end
      end
      ST_LEVEL: begin
        lv_issue = 1'b1;
        if ({1'b0, idx} == n - CNT_W'(2) - j) begin
          j_next     = j + CNT_W'(1);
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_EMIT: begin
        if (free) begin
          emit_last_next = ({1'b0, idx} == n - lv - CNT_W'(1));
          state_next     = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        o_load   = 1'b1;
        o_last_n = emit_last;
        if (emit_last) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = ST_EMIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // -------- memories --------
  assign ra_addr = idx;
  assign rb_addr = idx + AW'(1);

  always_ff @(posedge clk) begin
    if (ps_we) begin
      ps_mem[count[AW-1:0]] <= {cmd_x, cmd_y};
    end
    ps_rd <= ps_mem[idx];
  end

  assign wk_we = cp_v || s2_v;
  assign wk_wa = cp_v ? cp_addr : s2_addr;
  assign wk_wd = cp_v ? ps_rd : {nx, ny};

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_mem[wk_wa] <= wk_wd;
    end
    rd_a <= wk_mem[ra_addr];
    rd_b <= wk_mem[rb_addr];
  end

  // -------- lerp pipeline --------
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      cp_v <= cp_issue;
      s1_v <= lv_issue;
      s2_v <= s1_v;
    end
  end

  assign dx = DW'($signed(rd_b[2*CB-1:CB])) - DW'($signed(rd_a[2*CB-1:CB]));
  assign dy = DW'($signed(rd_b[CB-1:0]))    - DW'($signed(rd_a[CB-1:0]));
  assign px = PW'($signed({1'b0, t_reg})) * PW'(dx);
  assign py = PW'($signed({1'b0, t_reg})) * PW'(dy);

  always_ff @(posedge clk) begin
    cp_addr <= idx;
    s1_addr <= idx;
    s2_addr <= s1_addr;
    s2_ax   <= $signed(rd_a[2*CB-1:CB]);
    s2_ay   <= $signed(rd_a[CB-1:0]);
    s2_px   <= px;
    s2_py   <= py;
  end

  // round half up: add one half then floor
  assign rx_sum = s2_px + $signed(HALF);
  assign ry_sum = s2_py + $signed(HALF);
  assign rx     = rx_sum[PW-1:FRAC_BITS];
  assign ry     = ry_sum[PW-1:FRAC_BITS];
  assign nx     = CB'(SW'(s2_ax) + rx);
  assign ny     = CB'(SW'(s2_ay) + ry);

  // -------- output register --------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_x  <= o_zero ? '0 : $signed(rd_a[2*CB-1:CB]);
      out_y  <= o_zero ? '0 : $signed(rd_a[CB-1:0]);
      last   <= o_last_n;
      status <= o_stat_n;
    end
  end
endmodule
`default_nettype wire

// File: design/bezier_de_casteljau_eval_core.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval_core
// 2D de Casteljau Bezier evaluator over a list of Q12.12 control points.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat carries kind, a point for
// append, and t_param and levels for evaluate. Unused kinds are dropped.
// Output channel (out_valid / out_stall): one beat per result point, with
// last set on the final point of an evaluation and on error results.
// A two-entry queue decouples the front from the back, so input beats are
// taken while a result waits for the receiver.
// Append and clear are handled in the back end's idle state. Evaluate of n
// points and L levels (capped at n-1) copies the points, runs L lerp passes
// (n-1-j lerps in pass j) and emits the remaining points; the single shared
// lerp pipeline takes one point pair a cycle within a pass and drains between
// passes. An error result is loaded once the output register is free.
// Reset empties the point list, the queue and the output register; stored
// points are not cleared. While out_stall is high the result beat holds and
// the back end holds its next result; the queue may fill and raise in_stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bezier_de_casteljau_eval_core_macros.svh"
module bezier_de_casteljau_eval_core #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   kind,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic [bdc_pkg::T_BITS-1:0]   t_param,
  input  wire logic [bdc_pkg::LV_BITS-1:0]  levels,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic                              last,
  output logic [1:0]                        status
);
  import bdc_pkg::*;

  localparam int QW = $bits(cmd_ctl_t) + 2 * COORD_BITS;

  logic              q_full, push, cmd_valid, cmd_pop;
  cmd_ctl_t          push_ctl, cmd_ctl;
  logic [COORD_BITS-1:0] push_x, push_y, cmd_x, cmd_y;
  logic [QW-1:0]     q_data;

  // Front: classify the beat and saturate t.
  bdc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .t_param  (t_param),
    .levels   (levels),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_x   (push_x),
    .push_y   (push_y)
  );

  // Queue: hold commands while the back end is busy.
  bdc_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_x, push_y}),
    .full      (q_full),
    .pop       (cmd_pop),
    .q_valid   (cmd_valid),
    .q_data    (q_data)
  );

  assign cmd_ctl = q_data[QW-1:2*COORD_BITS];
  assign cmd_x   = q_data[2*COORD_BITS-1:COORD_BITS];
  assign cmd_y   = q_data[COORD_BITS-1:0];

  // Back: store points, run the lerp passes, drive result beats.
  bdc_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_ctl   (cmd_ctl),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .last      (last),
    .status    (status)
  );

  // Error beats close their run and carry a zero point.
  `BDC_ASSERT_IMPL(a_err_last, out_valid && status != STAT_OK, last)
  `BDC_ASSERT_IMPL(a_err_zero, out_valid && status != STAT_OK, out_x == '0 && out_y == '0)
  // The back end only takes a command that the queue holds.
  `BDC_ASSERT_IMPL(a_pop_valid, cmd_pop, cmd_valid)
endmodule
`default_nettype wire
